// ----- src/scl_pkg.sv -----
// shared types and constants of the scaling list delta codec
package scl_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_DIRECTION = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_LIST_SIZE = 1'b1;

   localparam logic DIR_DECODE = 1'b0;
   localparam logic DIR_ENCODE = 1'b1;

   localparam logic [7:0] INIT_SCALE     = 8'd8;
   localparam logic [6:0] LIST_SIZE_INIT = 7'd16;

   typedef struct packed {
      logic       direction;
      logic [6:0] list_size;
      logic       restart;
   } cfg_type;

   typedef struct packed {
      logic [7:0]        scale_out;
      logic signed [7:0] delta_out;
      logic              use_default;
      logic              end_of_list;
   } rsp_type;

endpackage

// ----- src/scl_if.sv -----
// request and response channel interfaces of the scaling list delta codec
interface scl_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] delta_in;
   logic [7:0]        entry_in;
   logic              want_default;

   modport source (output valid, delta_in, entry_in, want_default, input ready);
   modport sink   (input valid, delta_in, entry_in, want_default, output ready);
endinterface

interface scl_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        scale_out;
   logic signed [7:0] delta_out;
   logic              use_default;
   logic              end_of_list;

   modport source (output valid, scale_out, delta_out, use_default, end_of_list, input ready);
   modport sink   (input valid, scale_out, delta_out, use_default, end_of_list, output ready);
endinterface

// ----- src/scaling_list_delta_codec_top.sv -----
// top level of the scaling list delta codec: control registers, sequencer and list memory
//
// codes one scaling list of list_size entries (zero counts as one, values above
// MAX_ENTRIES saturate). decode (direction 0): each request beat carries a signed
// delta and normally gives one response beat, the entry (previous + delta) mod 256,
// with previous starting at 8. a delta that gives zero ends the list: that entry and
// all remaining ones repeat the previous value, one response beat per cycle while the
// response side keeps up, and use_default is set on them when it was the first delta.
// encode (direction 1): request beats load entries into the list memory and give no
// response until the last one; want_default is sampled on the first entry. after the
// last entry the block trims trailing repeats (tracked while loading) and reads the
// kept entries back from the list memory, emitting their wrapped signed deltas, plus
// a closing delta back to zero when the list was cut short or default signalling was
// asked for. rate: one request beat per cycle while the response side keeps up. a zero
// delta in decode mode and the last encode entry each start a drain: the decode drain
// repeats the previous value to the end of the list; the encode drain primes the
// memory read, then emits one delta per kept entry and any closing delta, paced by
// the single read port of the list memory; with default signalling there is no read,
// only the closing delta. no request is taken during that drain. the memory needs no
// clearing pass after reset. response beats sit in a single output register; a new
// request beat is taken only while that register is empty or being emptied in the
// same cycle. writing either control register abandons a partial list; write them
// only while the block is idle.
module scaling_list_delta_codec_top
   import scl_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   scl_req_if.sink                req_bus,
   scl_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int AddrW = $clog2(MAX_ENTRIES);

   // control registers
   logic       direction_ff, direction_in;
   logic [6:0] list_size_ff, list_size_in;
   cfg_type    cfg;

   // list memory port
   logic             ram_wr_en;
   logic [AddrW-1:0] ram_wr_addr;
   logic [7:0]       ram_wr_data;
   logic [AddrW-1:0] ram_rd_addr;
   logic [7:0]       ram_rd_data;

   // register write decode
   always_comb begin
      direction_in = direction_ff;
      list_size_in = list_size_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_DIRECTION: direction_in = csr_wr_data[0];
            REG_LIST_SIZE: list_size_in = csr_wr_data[6:0];
            default:       direction_in = direction_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_DECODE;
         list_size_ff <= LIST_SIZE_INIT;
      end else begin
         direction_ff <= direction_in;
         list_size_ff <= list_size_in;
      end
   end

   // any register write restarts the list
   assign cfg.direction = direction_ff;
   assign cfg.list_size = list_size_ff;
   assign cfg.restart   = csr_wr_en &&
                          ((csr_index == REG_DIRECTION) || (csr_index == REG_LIST_SIZE));

   scl_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // list memory, written while loading, read back during the encode drain
   scl_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ENTRIES)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ----- src/scl_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module scl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/scl_ctrl.sv -----
// list sequencer: delta accumulate, run tracking, drain of results through the output register
module scl_ctrl
   import scl_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   localparam int AddrW = $clog2(MAX_ENTRIES),
   localparam int CntW  = $clog2(MAX_ENTRIES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   scl_req_if.sink          req,
   scl_rsp_if.source        rsp,
   output logic             ram_wr_en,
   output logic [AddrW-1:0] ram_wr_addr,
   output logic [7:0]       ram_wr_data,
   output logic [AddrW-1:0] ram_rd_addr,
   input  logic [7:0]       ram_rd_data
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DEC_FILL  = 3'd1;
   localparam logic [2:0] ST_ENC_PRIME = 3'd2;
   localparam logic [2:0] ST_ENC_EMIT  = 3'd3;
   localparam logic [2:0] ST_ENC_CLOSE = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [7:0]      prev_ff, prev_in;
   logic            defreq_ff, defreq_in;
   logic [CntW-1:0] run_ff, run_in;
   logic [7:0]      ent_ff, ent_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] halt_ff, halt_in;
   logic            usedef_ff, usedef_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_ff, out_in;

   logic [CntW-1:0] size_c;
   logic            out_free;
   logic            accept;
   logic [CntW-1:0] pos_nx1;
   logic [CntW-1:0] idx_nx1;
   logic            last_pos;
   logic [7:0]      next_val;
   logic [CntW-1:0] run_nx;
   logic            def_nx;
   logic [CntW-1:0] halt_c;

   // effective list length: zero means one, oversize saturates
   always_comb begin
      if (cfg.list_size == 7'd0) begin
         size_c = CntW'(1);
      end else if (cfg.list_size > 7'(MAX_ENTRIES)) begin
         size_c = CntW'(MAX_ENTRIES);
      end else begin
         size_c = CntW'(cfg.list_size);
      end
   end

   assign out_free  = !out_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign pos_nx1   = pos_ff + CntW'(1);
   assign idx_nx1   = idx_ff + CntW'(1);
   assign last_pos  = (pos_nx1 == size_c);
   assign next_val  = prev_ff + $unsigned(req.delta_in);

   // start of the trailing run of equal entries, and the kept length
   assign run_nx = (pos_ff == '0) ? '0 :
                   (req.entry_in != ent_ff) ? pos_ff : run_ff;
   assign def_nx = (pos_ff == '0) ? req.want_default : defreq_ff;
   assign halt_c = def_nx ? '0 : run_nx + CntW'(1);

   assign ram_wr_en   = accept && (cfg.direction == DIR_ENCODE);
   assign ram_wr_addr = pos_ff[AddrW-1:0];
   assign ram_wr_data = req.entry_in;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      prev_in      = prev_ff;
      defreq_in    = defreq_ff;
      run_in       = run_ff;
      ent_in       = ent_ff;
      idx_in       = idx_ff;
      halt_in      = halt_ff;
      usedef_in    = usedef_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in       = out_ff;
      ram_rd_addr  = idx_ff[AddrW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cfg.direction == DIR_DECODE) begin
                  out_valid_in = 1'b1;
                  out_in.delta_out   = '0;
                  out_in.end_of_list = last_pos;
                  if (next_val != 8'd0) begin
                     out_in.scale_out   = next_val;
                     out_in.use_default = 1'b0;
                     prev_in            = next_val;
                     pos_in             = last_pos ? '0 : pos_nx1;
                     if (last_pos) begin
                        prev_in = INIT_SCALE;
                     end
                  end else begin
                     // zero ends the list: repeat the previous value to the end
                     out_in.scale_out   = prev_ff;
                     out_in.use_default = (pos_ff == '0);
                     usedef_in          = (pos_ff == '0);
                     if (last_pos) begin
                        pos_in  = '0;
                        prev_in = INIT_SCALE;
                     end else begin
                        idx_in   = pos_nx1;
                        state_in = ST_DEC_FILL;
                     end
                  end
               end else begin
                  ent_in    = req.entry_in;
                  run_in    = run_nx;
                  defreq_in = def_nx;
                  if (!last_pos) begin
                     pos_in = pos_nx1;
                  end else begin
                     pos_in    = '0;
                     defreq_in = 1'b0;
                     prev_in   = INIT_SCALE;
                     halt_in   = halt_c;
                     idx_in    = '0;
                     state_in  = (halt_c == '0) ? ST_ENC_CLOSE : ST_ENC_PRIME;
                  end
               end
            end
         end
         ST_DEC_FILL: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.scale_out   = prev_ff;
               out_in.delta_out   = '0;
               out_in.use_default = usedef_ff;
               out_in.end_of_list = (idx_nx1 == size_c);
               if (idx_nx1 == size_c) begin
                  pos_in    = '0;
                  prev_in   = INIT_SCALE;
                  defreq_in = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in = idx_nx1;
               end
            end
         end
         ST_ENC_PRIME: begin
            ram_rd_addr = '0;
            state_in    = ST_ENC_EMIT;
         end
         ST_ENC_EMIT: begin
            // read data holds while stalled, next address goes out on a load
            if (out_free) begin
               ram_rd_addr        = idx_nx1[AddrW-1:0];
               out_valid_in       = 1'b1;
               out_in.scale_out   = '0;
               out_in.delta_out   = $signed(ram_rd_data - prev_ff);
               out_in.use_default = 1'b0;
               out_in.end_of_list = (idx_nx1 == halt_ff) && (halt_ff == size_c);
               prev_in            = ram_rd_data;
               if (idx_nx1 == halt_ff) begin
                  if (halt_ff == size_c) begin
                     prev_in  = INIT_SCALE;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_ENC_CLOSE;
                  end
               end else begin
                  idx_in = idx_nx1;
               end
            end
         end
         ST_ENC_CLOSE: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.scale_out   = '0;
               out_in.delta_out   = $signed(8'd0 - prev_ff);
               out_in.use_default = 1'b0;
               out_in.end_of_list = 1'b1;
               prev_in            = INIT_SCALE;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.restart) begin
         pos_in    = '0;
         prev_in   = INIT_SCALE;
         defreq_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         prev_ff      <= INIT_SCALE;
         defreq_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         prev_ff      <= prev_in;
         defreq_ff    <= defreq_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff    <= run_in;
      ent_ff    <= ent_in;
      idx_ff    <= idx_in;
      halt_ff   <= halt_in;
      usedef_ff <= usedef_in;
      out_ff    <= out_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.scale_out   = out_ff.scale_out;
   assign rsp.delta_out   = out_ff.delta_out;
   assign rsp.use_default = out_ff.use_default;
   assign rsp.end_of_list = out_ff.end_of_list;

endmodule

// ----- sim/scaling_list_delta_codec_top_tb.sv -----
// self-checking testbench of the scaling list delta codec top level
module scaling_list_delta_codec_top_tb
   import scl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // list memory depth of the block under test
   localparam int LIST_DEPTH    = 64;
   // random request beats after the directed table
   localparam int RAND_BEATS    = 160;
   // idle cycles after the last awaited beat before a register write or a pause ends
   localparam int SETTLE_CYCLES = 8;
   // tail of the run: longest list drain plus margin
   localparam int DRAIN_CYCLES  = 70;
   // longest correct stretch without a beat is an idle gap of the sender, a stall burst
   // of the receiver, a settle pause or the final drain, all far below this limit
   localparam int STALL_LIMIT   = 2000;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   // one directed row: a request beat, or a register write with its value in dlt
   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [7:0]             dlt;
      logic [7:0]             ent;
      logic                   wd;
      logic                   typed;
      rsp_type                exp;
   } dir_row_type;

   localparam rsp_type NO_RSP = '0;
   localparam int N_DIRECTED = 32;

   // rows with typed set cause exactly one response beat, written out here;
   // all other rows are checked against the list predictor
   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      // decode after reset, list size 16, previous value 8
      '{ROW_BEAT, '0, 8'h01, 8'h00, 1'b0, 1'b1, '{8'd9,   8'sd0, 1'b0, 1'b0}},
      // largest positive delta
      '{ROW_BEAT, '0, 8'h7F, 8'h00, 1'b0, 1'b1, '{8'd136, 8'sd0, 1'b0, 1'b0}},
      // most negative delta
      '{ROW_BEAT, '0, 8'h80, 8'h00, 1'b0, 1'b1, '{8'd8,   8'sd0, 1'b0, 1'b0}},
      // zero mid-list: thirteen repeats of 8 to the end
      '{ROW_BEAT, '0, 8'hF8, 8'hFF, 1'b1, 1'b0, NO_RSP},
      // zero on the first delta: whole list repeats with use_default
      '{ROW_BEAT, '0, 8'hF8, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{ROW_CSR,  REG_LIST_SIZE, 8'd1, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'hF9, 8'h00, 1'b0, 1'b1, '{8'd1,   8'sd0, 1'b0, 1'b1}},
      '{ROW_BEAT, '0, 8'hF8, 8'h00, 1'b0, 1'b1, '{8'd8,   8'sd0, 1'b1, 1'b1}},
      // size zero behaves as a one entry list
      '{ROW_CSR,  REG_LIST_SIZE, 8'd0, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h78, 8'h00, 1'b0, 1'b1, '{8'd128, 8'sd0, 1'b0, 1'b1}},
      // oversized list saturates to the memory depth
      '{ROW_CSR,  REG_LIST_SIZE, 8'd127, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h05, 8'h00, 1'b0, 1'b1, '{8'd13,  8'sd0, 1'b0, 1'b0}},
      '{ROW_BEAT, '0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd13,  8'sd0, 1'b0, 1'b0}},
      // switching to encode drops the partial decoded list
      '{ROW_CSR,  REG_DIRECTION, 8'(DIR_ENCODE), 8'h00, 1'b0, 1'b0, NO_RSP},
      '{ROW_CSR,  REG_LIST_SIZE, 8'd3, 8'h00, 1'b0, 1'b0, NO_RSP},
      // trailing repeat trimmed, then a closing delta back to zero
      '{ROW_BEAT, '0, 8'h00, 8'hFF, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h00, 8'h00, 1'b0, 1'b0, NO_RSP},
      // default request on the first entry: only the closing delta
      '{ROW_BEAT, '0, 8'h00, 8'h0A, 1'b1, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h00, 8'h14, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h00, 8'h1E, 1'b0, 1'b1, '{8'd0,  -8'sd8, 1'b0, 1'b1}},
      // all entries equal: one kept delta of zero plus the closing delta
      '{ROW_BEAT, '0, 8'h00, 8'h08, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h00, 8'h08, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h00, 8'h08, 1'b0, 1'b0, NO_RSP},
      '{ROW_CSR,  REG_LIST_SIZE, 8'd1, 8'h00, 1'b0, 1'b0, NO_RSP},
      // 200 - 8 wraps to a negative delta
      '{ROW_BEAT, '0, 8'h00, 8'hC8, 1'b0, 1'b1, '{8'd0, -8'sd64, 1'b0, 1'b1}},
      '{ROW_BEAT, '0, 8'h00, 8'h00, 1'b1, 1'b1, '{8'd0,  -8'sd8, 1'b0, 1'b1}},
      // partial encode list, then dropped by going back to decode
      '{ROW_CSR,  REG_LIST_SIZE, 8'd4, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h00, 8'h05, 1'b0, 1'b0, NO_RSP},
      '{ROW_BEAT, '0, 8'h00, 8'h06, 1'b0, 1'b0, NO_RSP},
      '{ROW_CSR,  REG_DIRECTION, 8'(DIR_DECODE), 8'h00, 1'b0, 1'b0, NO_RSP},
      // fresh list starts from 8 again
      '{ROW_BEAT, '0, 8'h01, 8'h00, 1'b0, 1'b1, '{8'd9,   8'sd0, 1'b0, 1'b0}}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   scl_req_if req_bus ();
   scl_rsp_if rsp_bus ();

   scaling_list_delta_codec_top #(
      .MAX_ENTRIES (LIST_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor copy of the list state and the two registers
   logic [7:0] codec_store [LIST_DEPTH];
   int         codec_pos;
   logic [7:0] codec_prev;
   logic       codec_defreq;
   logic       codec_dir;
   logic [6:0] codec_size;

   rsp_type awaited_rsp_q [$];   // response beats still to come, oldest first
   rsp_type step_out_q [$];      // beats caused by the latest request beat

   int  fail_count;
   int  beat_count;
   int  rsp_count;
   int  settings_count;
   int  default_lists;
   int  early_closes;
   int  pauses;
   bit  calm;                    // no idling on either side in the last part
   int  quiet_cycles;
   int  rsp_hold;
   rsp_type mon_got;
   rsp_type mon_want;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic void restart_codec();
      codec_pos    = 0;
      codec_prev   = INIT_SCALE;
      codec_defreq = 1'b0;
   endfunction

   // list size zero counts as one, oversized saturates
   function automatic int eff_size();
      if (codec_size == 0) return 1;
      if (codec_size > LIST_DEPTH) return LIST_DEPTH;
      return codec_size;
   endfunction

   // one request beat through the list codec, results into step_out_q
   function automatic void step_list_codec(input logic [7:0] dlt, input logic [7:0] ent,
                                           input logic wd);
      int         sz;
      int         pos;
      int         halt;
      logic [7:0] nxt;
      logic [7:0] last;
      rsp_type    r;
      step_out_q.delete();
      sz = eff_size();
      if (codec_pos >= sz) restart_codec();
      pos = codec_pos;
      if (codec_dir == DIR_DECODE) begin
         nxt = codec_prev + dlt;
         if (nxt != 8'd0) begin
            codec_store[pos] = nxt;
            codec_prev = nxt;
            r = '0;
            r.scale_out = nxt;
            r.end_of_list = (pos + 1 == sz);
            step_out_q.push_back(r);
            if (pos + 1 == sz) restart_codec();
            else codec_pos = pos + 1;
         end else begin
            // zero ends the list: this entry and the rest repeat the previous value
            if (pos == 0) default_lists++;
            for (int i = pos; i < sz; i++) begin
               codec_store[i] = codec_prev;
               r = '0;
               r.scale_out = codec_prev;
               r.use_default = (pos == 0);
               r.end_of_list = (i + 1 == sz);
               step_out_q.push_back(r);
            end
            restart_codec();
         end
         return;
      end
      codec_store[pos] = ent;
      if (pos == 0) codec_defreq = wd;
      if (pos + 1 < sz) begin
         codec_pos = pos + 1;
         return;
      end
      // last entry: trim trailing repeats, emit kept deltas, close if cut short
      halt = codec_defreq ? 0 : sz;
      last = INIT_SCALE;
      while (halt >= 2 && codec_store[halt-1] == codec_store[halt-2]) halt--;
      for (int i = 0; i < halt; i++) begin
         r = '0;
         r.delta_out = codec_store[i] - last;
         r.end_of_list = (i + 1 == halt && halt == sz);
         step_out_q.push_back(r);
         last = codec_store[i];
      end
      if (halt != sz) begin
         r = '0;
         r.delta_out = 8'd0 - last;
         r.end_of_list = 1'b1;
         step_out_q.push_back(r);
         early_closes++;
      end
      restart_codec();
   endfunction

   // drop valid, wait for every awaited beat, then let the block go quiet
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write enable held one edge, then an idle edge so back to back writes never
   // schedule two values for csr_wr_en in the same step
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_DIRECTION) codec_dir = val[0];
      else codec_size = val;
      restart_codec();
      settings_count++;
      @(posedge clock);
   endtask

   // one request beat, with an optional idle burst ahead of it
   task automatic send_beat(input logic [7:0] dlt, input logic [7:0] ent, input logic wd,
                            input logic typed, input rsp_type typed_rsp);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.delta_in     <= dlt;
      req_bus.entry_in     <= ent;
      req_bus.want_default <= wd;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // beat taken at this edge
      step_list_codec(dlt, ent, wd);
      if (typed) awaited_rsp_q.push_back(typed_rsp);
      else foreach (step_out_q[j]) awaited_rsp_q.push_back(step_out_q[j]);
      beat_count++;
   endtask

   // free running clock, 20 ns period
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response side: ready with random stall bursts
   initial begin
      rsp_bus.ready <= 1'b0;
      rsp_hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold = $urandom_range(0, 11);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // response checker: every accepted beat against the oldest awaited one
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         mon_got.scale_out   = rsp_bus.scale_out;
         mon_got.delta_out   = rsp_bus.delta_out;
         mon_got.use_default = rsp_bus.use_default;
         mon_got.end_of_list = rsp_bus.end_of_list;
         if (awaited_rsp_q.size() == 0) begin
            report_mismatch($sformatf("response beat %0d with nothing awaited", rsp_count));
         end else begin
            mon_want = awaited_rsp_q.pop_front();
            if (mon_got.scale_out !== mon_want.scale_out)
               report_mismatch($sformatf("beat %0d scale_out %0d, expected %0d", rsp_count,
                                         mon_got.scale_out, mon_want.scale_out));
            if (mon_got.delta_out !== mon_want.delta_out)
               report_mismatch($sformatf("beat %0d delta_out %0d, expected %0d", rsp_count,
                                         mon_got.delta_out, mon_want.delta_out));
            if (mon_got.use_default !== mon_want.use_default)
               report_mismatch($sformatf("beat %0d use_default %b, expected %b", rsp_count,
                                         mon_got.use_default, mon_want.use_default));
            if (mon_got.end_of_list !== mon_want.end_of_list)
               report_mismatch($sformatf("beat %0d end_of_list %b, expected %b", rsp_count,
                                         mon_got.end_of_list, mon_want.end_of_list));
         end
         rsp_count++;
      end
   end

   // watchdog: too long without any beat on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d still awaited",
                     quiet_cycles, awaited_rsp_q.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      int         sz;
      int         n_lists;
      int         brk;
      int         cut;
      int         pause_pos;
      int         phase_no;
      int         directed_beats;
      logic [6:0] size_pick;
      logic [7:0] ents [LIST_DEPTH];
      logic [7:0] base;
      logic [7:0] dl;
      logic       wd0;
      logic       enc;
      bit         forced;
      bit         broken;

      fail_count     = 0;
      beat_count     = 0;
      rsp_count      = 0;
      settings_count = 0;
      default_lists  = 0;
      early_closes   = 0;
      pauses         = 0;
      calm           = 1'b0;
      codec_dir      = DIR_DECODE;
      codec_size     = LIST_SIZE_INIT;
      restart_codec();

      // every input known from time zero
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= '0;
      csr_wr_data          <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.delta_in     <= '0;
      req_bus.entry_in     <= '0;
      req_bus.want_default <= 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: reset values first, writes only once the block is idle
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            settle_block();
            write_csr(DIRECTED[i].idx, DIRECTED[i].dlt[CSR_DATA_W-1:0]);
         end else begin
            send_beat(DIRECTED[i].dlt, DIRECTED[i].ent, DIRECTED[i].wd,
                      DIRECTED[i].typed, DIRECTED[i].exp);
         end
      end
      directed_beats = beat_count;

      // random phases: new settings each phase, mostly whole lists with random content
      phase_no = 0;
      while (beat_count - directed_beats < RAND_BEATS) begin
         if (beat_count - directed_beats >= RAND_BEATS * 3 / 4) calm = 1'b1;
         settle_block();
         write_csr(REG_DIRECTION, ($urandom_range(0, 1) == 0) ? CSR_DATA_W'(DIR_DECODE)
                                                             : CSR_DATA_W'(DIR_ENCODE));
         case ($urandom_range(0, 9))
            0: size_pick = 7'd0;
            1: size_pick = 7'd1;
            2: size_pick = 7'd64;
            3: size_pick = 7'd127;
            4: size_pick = 7'd16;
            5: size_pick = 7'($urandom_range(65, 126));
            default: size_pick = 7'($urandom_range(2, 12));
         endcase
         write_csr(REG_LIST_SIZE, size_pick);
         sz      = eff_size();
         enc     = codec_dir;
         n_lists = (sz >= 16) ? 1 : $urandom_range(2, 6);
         // sender holds off mid-list until all awaited beats are in, always in the
         // first phase
         pause_pos = (phase_no == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, sz-1)
                                                                 : -1;
         broken = 1'b0;
         for (int k = 0; k < n_lists && !broken; k++) begin
            // entries: some close to a base value so repeats and trims show up
            base = 8'($urandom);
            for (int i = 0; i < sz; i++)
               ents[i] = ($urandom_range(0, 3) == 0) ? base + 8'($urandom_range(0, 1))
                                                     : 8'($urandom);
            if ($urandom_range(0, 1) == 1) begin
               cut = $urandom_range(1, sz);
               for (int i = cut; i < sz; i++) ents[i] = ents[cut-1];
            end
            wd0 = ($urandom_range(0, 5) == 0);
            // now and then a list cut off, left for the next write to drop
            brk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, sz-1) : sz;
            for (int i = 0; i < brk; i++) begin
               if (k == 0 && i == pause_pos) begin
                  settle_block();
                  pauses++;
               end
               if (enc) begin
                  send_beat(8'($urandom), ents[i], (i == 0) ? wd0 : 1'($urandom),
                            1'b0, NO_RSP);
               end else begin
                  // a delta that lands on zero ends the decoded list early
                  forced = ($urandom_range(0, 15) == 0);
                  dl = forced ? 8'd0 - codec_prev : 8'($urandom);
                  send_beat(dl, 8'($urandom), 1'($urandom), 1'b0, NO_RSP);
                  if (forced) break;
               end
            end
            if (brk < sz) broken = 1'b1;
         end
         phase_no++;
      end

      // wind down: everything in, then the longest drain again
      req_bus.valid <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request beats (%0d from the table) and %0d response beats",
               beat_count, directed_beats, rsp_count);
      $display("%0d register writes, %0d default lists, %0d closing deltas, %0d pauses",
               settings_count, default_lists, early_closes, pauses);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
